// ===== design/lcfp_pkg.sv =====
// Package for the constant-power load current block: payload and pipeline types,
// fixed-point widths, register indexes and the CORDIC arctangent table.
// No dependencies; every other design file imports it.
package lcfp_pkg;

  // Field and datapath widths.
  localparam int MAG_W      = 16;  // voltage magnitude, unsigned Q2.14
  localparam int ANGLE_W    = 16;  // voltage angle, binary angle
  localparam int PWR_W      = 32;  // power set-points, signed Q16.16
  localparam int CUR_W      = 32;  // currents, signed Q16.16
  localparam int CS_W       = 32;  // CORDIC vector, signed Q1.30
  localparam int Z_W        = 34;  // CORDIC angle accumulator, 2^31 = pi
  localparam int PROD_W     = 64;  // products and numerators, Q.46
  localparam int QUO_W      = 32;  // quotient magnitude bits
  localparam int MAX_STEPS  = 32;  // length of the arctangent table
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_POWER   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REACTIVE_POWER = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_VALID = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONLINE         = 4'd3;

  // CORDIC constants: gain in Q1.30, quarter and half turn in 16-bit binary angle.
  localparam logic signed [CS_W-1:0]    CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [ANGLE_W:0]   HALF_PI_BAM = 17'sd16384;
  localparam logic signed [ANGLE_W:0]   PI_BAM      = 17'sd32768;

  // Saturation bounds of the current outputs.
  localparam logic [CUR_W-1:0] CUR_MAX     = 32'h7FFF_FFFF;
  localparam logic [CUR_W-1:0] CUR_MIN     = 32'h8000_0000;

  // Arctangent of 2^-i in 32-bit binary angle (2^31 = pi).
  localparam logic [31:0] ATAN_BAM [MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85150676,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Input transaction payload.
  typedef struct packed {
    logic [MAG_W-1:0]          voltage_magnitude;
    logic signed [ANGLE_W-1:0] voltage_angle;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [CUR_W-1:0] current_real;
    logic signed [CUR_W-1:0] current_imag;
    logic                    error_flag;
  } out_t;

  // State handed from one CORDIC cell to the next.
  typedef struct packed {
    logic                    valid;
    logic                    zero;   // force zero current
    logic                    err;    // error flag when forced to zero
    logic                    flip;   // angle was folded by pi
    logic [MAG_W-1:0]        vm;
    logic signed [CS_W-1:0]  x;
    logic signed [CS_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_t;

  // Control that travels alongside the divider lanes.
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             err;
    logic             neg_r;
    logic             neg_i;
    logic             big_r;  // quotient at least 2^32
    logic             big_i;
    logic [MAG_W-1:0] vm;
  } div_side_t;

  // State handed from one divider cell to the next.
  typedef struct packed {
    div_side_t        side;
    logic [MAG_W-1:0] rem_r;
    logic [QUO_W-1:0] dq_r;   // dividend bits shift out, quotient bits shift in
    logic [MAG_W-1:0] rem_i;
    logic [QUO_W-1:0] dq_i;
  } div_t;

endpackage

// ===== design/lcfp_cordic_cell.sv =====
// One rotation-mode CORDIC step with its output register.
// Depends on lcfp_pkg for cordic_t and the arctangent table.
module lcfp_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  lcfp_pkg::cordic_t cell_in,
  output lcfp_pkg::cordic_t cell_out
);
  import lcfp_pkg::*;

  cordic_t                st_r;
  cordic_t                st_nxt;
  logic signed [CS_W-1:0] x_sh;
  logic signed [CS_W-1:0] y_sh;
  logic signed [Z_W-1:0]  atan_z;

  // Rotate toward zero residual angle; shifts round toward minus infinity.
  always_comb begin
    x_sh   = cell_in.x >>> STEP;
    y_sh   = cell_in.y >>> STEP;
    atan_z = signed'({{(Z_W-32){1'b0}}, ATAN_BAM[STEP]});
    st_nxt = cell_in;
    if (!cell_in.z[Z_W-1]) begin
      st_nxt.x = cell_in.x - y_sh;
      st_nxt.y = cell_in.y + x_sh;
      st_nxt.z = cell_in.z - atan_z;
    end else begin
      st_nxt.x = cell_in.x + y_sh;
      st_nxt.y = cell_in.y - x_sh;
      st_nxt.z = cell_in.z + atan_z;
    end
  end

  // Only the valid bit needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign cell_out = st_r;

endmodule

// ===== design/lcfp_div_cell.sv =====
// One restoring division step for both current lanes, with its output register.
// Depends on lcfp_pkg for div_t.
module lcfp_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  lcfp_pkg::div_t cell_in,
  output lcfp_pkg::div_t cell_out
);
  import lcfp_pkg::*;

  div_t           st_r;
  div_t           st_nxt;
  logic [MAG_W:0] t_r;
  logic [MAG_W:0] t_i;
  logic [MAG_W:0] dvs;
  logic           ge_r;
  logic           ge_i;

  // Bring down the next dividend bit, subtract the divisor when it fits.
  always_comb begin
    dvs    = {1'b0, cell_in.side.vm};
    t_r    = {cell_in.rem_r, cell_in.dq_r[QUO_W-1]};
    t_i    = {cell_in.rem_i, cell_in.dq_i[QUO_W-1]};
    ge_r   = (t_r >= dvs);
    ge_i   = (t_i >= dvs);
    st_nxt = cell_in;
    st_nxt.rem_r = ge_r ? MAG_W'(t_r - dvs) : t_r[MAG_W-1:0];
    st_nxt.rem_i = ge_i ? MAG_W'(t_i - dvs) : t_i[MAG_W-1:0];
    st_nxt.dq_r  = {cell_in.dq_r[QUO_W-2:0], ge_r};
    st_nxt.dq_i  = {cell_in.dq_i[QUO_W-2:0], ge_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.side.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign cell_out = st_r;

endmodule

// ===== design/load_current_from_power.sv =====
// Constant-power load current injection. Each input transaction (bus voltage
// magnitude and angle) yields one result transaction with the injected current
// (P cos a + Q sin a)/V, (P sin a - Q cos a)/V in Q16.16 and an error flag.
// The block is a pipeline that takes one transaction per clock cycle unless it is
// stalled; its registers are one per CORDIC cell (ROTATION_STEPS, capped at 32
// rotation cells), the multiply, sum and magnitude stages, the bit-per-cell
// divider chain and the output register. The output
// register lets a new transaction enter while a result waits, and empty
// slots at the tail of the pipeline are squeezed out during a stall.
// Configuration writes are always ready and must be made while the block is idle.
// Depends on lcfp_pkg, lcfp_cordic_cell and lcfp_div_cell.
module load_current_from_power #(
  parameter int ROTATION_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lcfp_pkg::in_t                     in_data,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output lcfp_pkg::out_t                    out_data,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcfp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lcfp_pkg::*;

  localparam int CELLS = (ROTATION_STEPS > MAX_STEPS) ? MAX_STEPS : ROTATION_STEPS;

  // Product stage.
  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic                     err;
    logic [MAG_W-1:0]         vm;
    logic signed [PROD_W-1:0] prc;
    logic signed [PROD_W-1:0] qs;
    logic signed [PROD_W-1:0] ps;
    logic signed [PROD_W-1:0] qc;
  } mul_t;

  // Numerator stage.
  typedef struct packed {
    logic                     valid;
    logic                     zero;
    logic                     err;
    logic [MAG_W-1:0]         vm;
    logic signed [PROD_W-1:0] num_r;
    logic signed [PROD_W-1:0] num_i;
  } sum_t;

  // Configuration registers.
  logic signed [PWR_W-1:0] load_p_r;
  logic signed [PWR_W-1:0] load_q_r;
  logic                    setpoint_valid_r;
  logic                    online_r;

  logic                    en;
  cordic_t                 cord [CELLS+1];
  mul_t                    mul_r;
  mul_t                    mul_nxt;
  sum_t                    sum_r;
  sum_t                    sum_nxt;
  div_t                    div [QUO_W+1];
  div_t                    div_nxt;
  logic signed [ANGLE_W:0] ang;
  logic signed [ANGLE_W:0] ang_red;
  logic signed [CS_W-1:0]  c_eff;
  logic signed [CS_W-1:0]  s_eff;
  logic [PROD_W-1:0]       mag_r;
  logic [PROD_W-1:0]       mag_i;
  logic [CUR_W:0]          sat_r;
  logic [CUR_W:0]          sat_i;
  out_t                    res;
  out_t                    out_data_r;
  logic                    out_valid_r;

  // Register writes; indexes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_p_r         <= '0;
      load_q_r         <= '0;
      setpoint_valid_r <= 1'b0;
      online_r         <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE_POWER:   load_p_r         <= signed'(cfg_data[PWR_W-1:0]);
        REG_REACTIVE_POWER: load_q_r         <= signed'(cfg_data[PWR_W-1:0]);
        REG_SETPOINT_VALID: setpoint_valid_r <= cfg_data[0];
        REG_ONLINE:         online_r         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a result sits in the last stage and the
  // output register is holding one that is not being taken.
  assign en       = out_ready || !out_valid_r || !div[QUO_W].side.valid;
  assign in_ready = en;

  // Fold the angle into [-pi/2, pi/2] and classify the special cases.
  always_comb begin
    ang     = {in_data.voltage_angle[ANGLE_W-1], in_data.voltage_angle};
    ang_red = ang;
    cord[0] = '0;
    if (ang > HALF_PI_BAM) begin
      ang_red      = ang - PI_BAM;
      cord[0].flip = 1'b1;
    end else if (ang < -HALF_PI_BAM) begin
      ang_red      = ang + PI_BAM;
      cord[0].flip = 1'b1;
    end
    cord[0].valid = in_valid;
    cord[0].vm    = in_data.voltage_magnitude;
    cord[0].x     = CORDIC_GAIN;
    cord[0].y     = '0;
    cord[0].z     = {ang_red[ANGLE_W], ang_red, 16'b0};
    if (!setpoint_valid_r) begin
      cord[0].zero = 1'b1;
      cord[0].err  = 1'b1;
    end else if (!online_r) begin
      cord[0].zero = 1'b1;
      cord[0].err  = 1'b0;
    end else if (in_data.voltage_magnitude == '0) begin
      cord[0].zero = 1'b1;
      cord[0].err  = 1'b1;
    end
  end

  // CORDIC cell chain.
  for (genvar g = 0; g < CELLS; g++) begin : g_cordic
    lcfp_cordic_cell #(
      .STEP (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (cord[g]),
      .cell_out (cord[g+1])
    );
  end

  // Products with the fold undone on cos and sin.
  always_comb begin
    c_eff         = cord[CELLS].flip ? -cord[CELLS].x : cord[CELLS].x;
    s_eff         = cord[CELLS].flip ? -cord[CELLS].y : cord[CELLS].y;
    mul_nxt.valid = cord[CELLS].valid;
    mul_nxt.zero  = cord[CELLS].zero;
    mul_nxt.err   = cord[CELLS].err;
    mul_nxt.vm    = cord[CELLS].vm;
    mul_nxt.prc   = load_p_r * c_eff;
    mul_nxt.qs    = load_q_r * s_eff;
    mul_nxt.ps    = load_p_r * s_eff;
    mul_nxt.qc    = load_q_r * c_eff;
  end

  // Numerators.
  always_comb begin
    sum_nxt.valid = mul_r.valid;
    sum_nxt.zero  = mul_r.zero;
    sum_nxt.err   = mul_r.err;
    sum_nxt.vm    = mul_r.vm;
    sum_nxt.num_r = mul_r.prc + mul_r.qs;
    sum_nxt.num_i = mul_r.ps - mul_r.qc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r.valid <= 1'b0;
      sum_r.valid <= 1'b0;
    end else if (en) begin
      mul_r <= mul_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Sign and magnitude; drop the 2^16 of the divisor by truncating the
  // magnitude, and flag quotients of 2^32 and above before division.
  always_comb begin
    mag_r = sum_r.num_r[PROD_W-1] ? PROD_W'(-sum_r.num_r) : PROD_W'(sum_r.num_r);
    mag_i = sum_r.num_i[PROD_W-1] ? PROD_W'(-sum_r.num_i) : PROD_W'(sum_r.num_i);
    div_nxt.side.valid = sum_r.valid;
    div_nxt.side.zero  = sum_r.zero;
    div_nxt.side.err   = sum_r.err;
    div_nxt.side.vm    = sum_r.vm;
    div_nxt.side.neg_r = sum_r.num_r[PROD_W-1];
    div_nxt.side.neg_i = sum_r.num_i[PROD_W-1];
    div_nxt.side.big_r = (mag_r[PROD_W-1:PROD_W-MAG_W] >= sum_r.vm);
    div_nxt.side.big_i = (mag_i[PROD_W-1:PROD_W-MAG_W] >= sum_r.vm);
    div_nxt.rem_r      = mag_r[PROD_W-1:PROD_W-MAG_W];
    div_nxt.rem_i      = mag_i[PROD_W-1:PROD_W-MAG_W];
    div_nxt.dq_r       = mag_r[PROD_W-MAG_W-1:16];
    div_nxt.dq_i       = mag_i[PROD_W-MAG_W-1:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div[0].side.valid <= 1'b0;
    end else if (en) begin
      div[0] <= div_nxt;
    end
  end

  // Divider cell chain, one quotient bit per cell.
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    lcfp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (div[g]),
      .cell_out (div[g+1])
    );
  end

  // Apply the sign and saturate; the top bit of the result is the overflow.
  function automatic logic [CUR_W:0] saturate(input logic neg, input logic big,
                                               input logic [QUO_W-1:0] q);
    logic [CUR_W:0] r;
    if (!neg) begin
      if (big || q[QUO_W-1]) r = {1'b1, CUR_MAX};
      else                   r = {1'b0, q};
    end else begin
      if (big || (q > CUR_MIN)) r = {1'b1, CUR_MIN};
      else                      r = {1'b0, CUR_W'(-q)};
    end
    return r;
  endfunction

  always_comb begin
    sat_r = saturate(div[QUO_W].side.neg_r, div[QUO_W].side.big_r, div[QUO_W].dq_r);
    sat_i = saturate(div[QUO_W].side.neg_i, div[QUO_W].side.big_i, div[QUO_W].dq_i);
    if (div[QUO_W].side.zero) begin
      res.current_real = '0;
      res.current_imag = '0;
      res.error_flag   = div[QUO_W].side.err;
    end else begin
      res.current_real = signed'(sat_r[CUR_W-1:0]);
      res.current_imag = signed'(sat_i[CUR_W-1:0]);
      res.error_flag   = sat_r[CUR_W] | sat_i[CUR_W];
    end
  end

  // Output register: holds a result until its transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_ready) || (en && div[QUO_W].side.valid);
    end
  end

  always_ff @(posedge clk) begin
    if (en && div[QUO_W].side.valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input is refused only behind a full, stalled output register.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && div[QUO_W].side.valid))
    else $error("input refused without a stalled result");

  // A new result appears only from a filled last pipeline stage.
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(div[QUO_W].side.valid))
    else $error("result appeared without a pipeline item");

  // When no overflow was flagged, the first partial remainder is below the divisor.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (div[0].side.valid && !div[0].side.zero && !div[0].side.big_r && !div[0].side.big_i)
      |-> (div[0].rem_r < div[0].side.vm && div[0].rem_i < div[0].side.vm))
    else $error("divider started with remainder not below divisor");

  // Forced-zero items leave the block with zero current.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en && div[QUO_W].side.valid && div[QUO_W].side.zero)
      |=> (out_data_r.current_real == '0 && out_data_r.current_imag == '0))
    else $error("forced-zero item gave nonzero current");

endmodule
